// File: rtl/core/lcs_pkg.sv
// Package for the longest common subsequence length engine.
// Holds request codes, the sequencer state type and the cell-unit control struct.
// No dependencies.
package lcs_pkg;

  localparam int CHAR_W = 8;
  localparam int REQ_W  = 2;
  localparam int OUT_W  = 7;

  localparam logic [REQ_W-1:0] REQ_LOAD_A  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD_B  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_COMPUTE = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CELL,
    S_DRAIN,
    S_OUT
  } seq_state_t;

  typedef struct packed {
    logic issue;
    logic first_row;
    logic first_cell;
  } cell_ctrl_t;

endpackage

// File: rtl/core/lcs_byte_mem.sv
// Byte-wide string store with one write port and one registered read port.
// Depends on lcs_pkg.
module lcs_byte_mem
  import lcs_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [CHAR_W-1:0] wr_data,
  input  logic [AW-1:0]     rd_addr,
  output logic [CHAR_W-1:0] rd_data
);

  logic [CHAR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/core/lcs_cell_unit.sv
// Shared table cell unit: holds the score row memory and computes one cell per cycle.
// Depends on lcs_pkg.
module lcs_cell_unit
  import lcs_pkg::*;
#(
  parameter int LW    = 7,
  parameter int DEPTH = 65
) (
  input  logic              clk,
  input  logic              rst,
  input  cell_ctrl_t        ctrl,
  input  logic [LW-1:0]     rd_addr,
  input  logic [CHAR_W-1:0] a_char,
  input  logic [CHAR_W-1:0] b_char,
  output logic [LW-1:0]     score
);

  logic [LW-1:0] row_mem [DEPTH];
  logic [LW-1:0] row_rdata;
  logic          v_d;
  logic          first_row_d;
  logic          first_cell_d;
  logic          fwd_d;
  logic [LW-1:0] wr_addr_d;
  logic [LW-1:0] diag;
  logic [LW-1:0] left;
  logic [LW-1:0] up;
  logic [LW-1:0] diag_in;
  logic [LW-1:0] left_in;
  logic [LW-1:0] cell_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_d   <= 1'b0;
      fwd_d <= 1'b0;
    end else begin
      v_d   <= ctrl.issue;
      fwd_d <= ctrl.issue && v_d && (rd_addr == wr_addr_d);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.issue) begin
      wr_addr_d    <= rd_addr;
      first_row_d  <= ctrl.first_row;
      first_cell_d <= ctrl.first_cell;
    end
    row_rdata <= row_mem[rd_addr];
    if (v_d) begin
      row_mem[wr_addr_d] <= cell_val;
      left               <= cell_val;
      diag               <= up;
    end
  end

  always_comb begin
    if (first_row_d) begin
      up = '0;
    end else if (fwd_d) begin
      up = left;
    end else begin
      up = row_rdata;
    end
    diag_in = first_cell_d ? '0 : diag;
    left_in = first_cell_d ? '0 : left;
    if (a_char == b_char) begin
      cell_val = diag_in + LW'(1);
    end else begin
      cell_val = (up > left_in) ? up : left_in;
    end
  end

  assign score = left;

endmodule

// File: rtl/core/longest_common_subsequence_length.sv
// Longest common subsequence length engine, top level with load logic and sequencer.
// Loads are accepted while idle; a compute steps through S_CELL, one table cell per cycle, then
// S_DRAIN and S_OUT (S_OUT alone if either string is empty) until ready again; S_OUT waits out any m_tready stall.
// The block is not ready during a compute; the result sits in an output register.
// Reset clears the lengths, the overflow flag and the output valid; stores are not cleared.
// Depends on lcs_pkg, lcs_byte_mem and lcs_cell_unit.
module longest_common_subsequence_length
  import lcs_pkg::*;
#(
  parameter int MAX_LEN = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] char_value
  input  logic [1:0] s_tuser,   // [1:0] req_type
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [6:0] lcs_length, [7] zero
  output logic [0:0] m_tuser    // [0] overflow
);

  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  seq_state_t        state;
  seq_state_t        state_next;
  logic [LW-1:0]     length_a;
  logic [LW-1:0]     length_b;
  logic              dropped;
  logic              empty;
  logic [LW-1:0]     i;
  logic [LW-1:0]     j;
  logic [LW-1:0]     j_m1;
  logic              accept;
  logic              wr_a;
  logic              wr_b;
  logic              row_end;
  logic              last_row;
  logic              out_load;
  logic [LW-1:0]     result;
  logic [LW+6:0]     result_wide;
  logic [CHAR_W-1:0] a_char;
  logic [CHAR_W-1:0] b_char;
  logic [LW-1:0]     score;
  cell_ctrl_t        ctrl;

  assign accept   = s_tvalid && s_tready;
  assign wr_a     = accept && (s_tuser == REQ_LOAD_A) && (length_a < LW'(MAX_LEN));
  assign wr_b     = accept && (s_tuser == REQ_LOAD_B) && (length_b < LW'(MAX_LEN));
  assign j_m1     = j - LW'(1);
  assign row_end  = (j == length_b);
  assign last_row = ((i + LW'(1)) == length_a);
  assign result   = empty ? '0 : score;

  lcs_byte_mem #(.DEPTH(MAX_LEN), .AW(AW)) u_mem_a (
    .clk     (clk),
    .wr_en   (wr_a),
    .wr_addr (length_a[AW-1:0]),
    .wr_data (s_tdata),
    .rd_addr (i[AW-1:0]),
    .rd_data (a_char)
  );

  lcs_byte_mem #(.DEPTH(MAX_LEN), .AW(AW)) u_mem_b (
    .clk     (clk),
    .wr_en   (wr_b),
    .wr_addr (length_b[AW-1:0]),
    .wr_data (s_tdata),
    .rd_addr (j_m1[AW-1:0]),
    .rd_data (b_char)
  );

  lcs_cell_unit #(.LW(LW), .DEPTH(MAX_LEN + 1)) u_cell (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .rd_addr (j),
    .a_char  (a_char),
    .b_char  (b_char),
    .score   (score)
  );

  always_comb begin
    state_next      = state;
    s_tready        = 1'b0;
    out_load        = 1'b0;
    ctrl.issue      = 1'b0;
    ctrl.first_row  = (i == '0);
    ctrl.first_cell = (j == LW'(1));
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid && (s_tuser == REQ_COMPUTE)) begin
          if ((length_a == '0) || (length_b == '0)) begin
            state_next = S_OUT;
          end else begin
            state_next = S_CELL;
          end
        end
      end
      S_CELL: begin
        ctrl.issue = 1'b1;
        if (row_end && last_row) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length_a <= '0;
      length_b <= '0;
      dropped  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (wr_a) begin
        length_a <= length_a + LW'(1);
      end
      if (wr_b) begin
        length_b <= length_b + LW'(1);
      end
      if (accept && (s_tuser == REQ_LOAD_A) && !wr_a) begin
        dropped <= 1'b1;
      end
      if (accept && (s_tuser == REQ_LOAD_B) && !wr_b) begin
        dropped <= 1'b1;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
        length_a <= '0;
        length_b <= '0;
        dropped  <= 1'b0;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign result_wide = {7'd0, result};

  always_ff @(posedge clk) begin
    if (accept && (s_tuser == REQ_COMPUTE)) begin
      empty <= (length_a == '0) || (length_b == '0);
      i     <= '0;
      j     <= LW'(1);
    end else if (state == S_CELL) begin
      if (row_end) begin
        j <= LW'(1);
        if (!last_row) begin
          i <= i + LW'(1);
        end
      end else begin
        j <= j + LW'(1);
      end
    end
    if (out_load) begin
      m_tdata <= {1'b0, result_wide[OUT_W-1:0]};
      m_tuser <= dropped;
    end
  end

endmodule
